// File: hdl/asc_pkg.sv
// Package for the accelerometer step counter.
// Holds configuration register indexes, field widths and the configuration struct.
// No dependencies.
package asc_pkg;

    localparam int RAW_W   = 16;
    localparam int AXIS_W  = 14;
    localparam int AMG_W   = 13;
    localparam int MAG_W   = 15;
    localparam int CNT_W   = 16;
    localparam int RANGE_W = 2;
    localparam int THR_W   = 15;
    localparam int MULT_W  = 5;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    localparam logic [IDX_W-1:0] CFG_RANGE     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HIGH_THR  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_LOW_THR   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RELOAD    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MULT      = 3'd4;

    localparam logic [RANGE_W-1:0] RANGE_2G = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_4G = 2'd1;

    localparam logic [RANGE_W-1:0] RESET_RANGE    = 2'd0;
    localparam logic [THR_W-1:0]   RESET_HIGH_THR = 15'd2000;
    localparam logic [THR_W-1:0]   RESET_LOW_THR  = 15'd1900;
    localparam logic [CNT_W-1:0]   RESET_RELOAD   = 16'd150;
    localparam logic [MULT_W-1:0]  RESET_MULT     = 5'd4;

    localparam logic [9:0] MG_PER_G = 10'd1000;

    typedef struct packed {
        logic [RANGE_W-1:0] range_select;
        logic [THR_W-1:0]   high_threshold;
        logic [THR_W-1:0]   low_threshold;
        logic [CNT_W-1:0]   window_reload;
        logic [MULT_W-1:0]  rate_multiplier;
    } t_cfg;

endpackage

// File: hdl/asc_axis_lane.sv
// One axis lane: scales a left-justified 14-bit axis word to absolute milli-g.
// Registered output; uses asc_pkg.
module asc_axis_lane (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [asc_pkg::RAW_W-1:0]    i_raw,
    input  logic [asc_pkg::RANGE_W-1:0]         i_range,
    output logic [asc_pkg::AMG_W-1:0]           o_abs_mg
);

    logic [asc_pkg::AXIS_W-1:0]   w_val;
    logic [asc_pkg::AXIS_W-1:0]   w_abs;
    logic [23:0]                  w_prod;
    logic [23:0]                  w_shifted;
    logic [asc_pkg::AMG_W-1:0]    r_abs_mg;

    assign w_val  = i_raw[asc_pkg::RAW_W-1:2];
    assign w_abs  = w_val[asc_pkg::AXIS_W-1] ? (~w_val + 14'd1) : w_val;
    assign w_prod = {10'd0, w_abs} * {14'd0, asc_pkg::MG_PER_G};

    always_comb begin
        case (i_range)
            asc_pkg::RANGE_2G: w_shifted = w_prod >> 12;
            asc_pkg::RANGE_4G: w_shifted = w_prod >> 11;
            default:           w_shifted = w_prod >> 10;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs_mg <= w_shifted[asc_pkg::AMG_W-1:0];
        end
    end

    assign o_abs_mg = r_abs_mg;

endmodule

// File: hdl/asc_step_tracker.sv
// Step detector with hysteresis and rate window counter; holds the result registers.
// Uses asc_pkg for widths and the configuration struct.
module asc_step_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [asc_pkg::MAG_W-1:0]   i_mag,
    input  asc_pkg::t_cfg               i_cfg,
    output logic [asc_pkg::MAG_W-1:0]   o_magnitude_mg,
    output logic                        o_step_seen,
    output logic [asc_pkg::CNT_W-1:0]   o_step_total,
    output logic                        o_rate_valid,
    output logic [asc_pkg::CNT_W-1:0]   o_steps_per_minute
);

    logic                        r_seeking;
    logic [asc_pkg::CNT_W-1:0]   r_step_count;
    logic [asc_pkg::CNT_W-1:0]   r_window_left;
    logic [asc_pkg::CNT_W-1:0]   r_count_at_window;
    logic [asc_pkg::CNT_W-1:0]   r_rate_hold;
    logic [asc_pkg::MAG_W-1:0]   r_mag;
    logic                        r_seen;
    logic                        r_rate_valid;

    logic                        w_still_seeking;
    logic                        w_step;
    logic                        n_seeking;
    logic [asc_pkg::CNT_W-1:0]   n_step_count;
    logic                        w_close;
    logic [asc_pkg::CNT_W-1:0]   w_diff;
    logic [20:0]                 w_rate;
    logic [asc_pkg::CNT_W-1:0]   w_rate_sat;

    assign w_still_seeking = r_seeking && !(i_mag > i_cfg.high_threshold);
    assign w_step          = !w_still_seeking && (i_mag < i_cfg.low_threshold);
    assign n_seeking       = w_still_seeking || w_step;
    assign n_step_count    = r_step_count + {{(asc_pkg::CNT_W-1){1'b0}}, w_step};
    assign w_close         = (r_window_left == '0);
    assign w_diff          = n_step_count - r_count_at_window;
    assign w_rate          = {5'd0, w_diff} * {16'd0, i_cfg.rate_multiplier};
    assign w_rate_sat      = (w_rate[20:16] != 5'd0) ? 16'hFFFF : w_rate[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeking         <= 1'b1;
            r_step_count      <= '0;
            r_window_left     <= '0;
            r_count_at_window <= '0;
            r_rate_hold       <= '0;
        end else if (i_en) begin
            r_seeking    <= n_seeking;
            r_step_count <= n_step_count;
            if (w_close) begin
                r_rate_hold       <= w_rate_sat;
                r_count_at_window <= n_step_count;
                r_window_left     <= i_cfg.window_reload;
            end else begin
                r_window_left <= r_window_left - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag        <= i_mag;
            r_seen       <= w_step;
            r_rate_valid <= w_close;
        end
    end

    assign o_magnitude_mg     = r_mag;
    assign o_step_seen        = r_seen;
    assign o_step_total       = r_step_count;
    assign o_rate_valid       = r_rate_valid;
    assign o_steps_per_minute = r_rate_hold;

    a_step_increments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> (r_step_count == $past(r_step_count) + {15'd0, r_seen}))
        else $error("step count out of step with step flag");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_step_count) && $stable(r_window_left) && $stable(r_seeking)))
        else $error("tracker state moved without an item");

    a_window_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_window_left == '0) |=>
            (r_rate_valid && r_count_at_window == r_step_count))
        else $error("window close did not report and reload");

endmodule

// File: hdl/accel_step_counter_unit.sv
// Accelerometer step counter: three axis lanes, magnitude merge, step tracker.
// Pipeline: 3 register stages (lanes, merge, tracker).
// Throughput: one item per cycle; the input stalls only when the output stalls
// with all three stages full.
// Reset: synchronous active-low; clears the pipeline valid flags, tracker state and config
// registers to their defaults. Uses asc_pkg, asc_axis_lane, asc_step_tracker.
module accel_step_counter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [asc_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [asc_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [asc_pkg::RAW_W-1:0]    i_x_raw,
    input  logic signed [asc_pkg::RAW_W-1:0]    i_y_raw,
    input  logic signed [asc_pkg::RAW_W-1:0]    i_z_raw,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [asc_pkg::MAG_W-1:0]           o_magnitude_mg,
    output logic                                o_step_seen,
    output logic [asc_pkg::CNT_W-1:0]           o_step_total,
    output logic                                o_rate_valid,
    output logic [asc_pkg::CNT_W-1:0]           o_steps_per_minute
);

    asc_pkg::t_cfg              r_cfg;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       w_en1;
    logic                       w_en2;
    logic                       w_en3;
    logic [asc_pkg::AMG_W-1:0]  w_abs_x;
    logic [asc_pkg::AMG_W-1:0]  w_abs_y;
    logic [asc_pkg::AMG_W-1:0]  w_abs_z;
    logic [asc_pkg::MAG_W-1:0]  r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_select    <= asc_pkg::RESET_RANGE;
            r_cfg.high_threshold  <= asc_pkg::RESET_HIGH_THR;
            r_cfg.low_threshold   <= asc_pkg::RESET_LOW_THR;
            r_cfg.window_reload   <= asc_pkg::RESET_RELOAD;
            r_cfg.rate_multiplier <= asc_pkg::RESET_MULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                asc_pkg::CFG_RANGE:
                    r_cfg.range_select <= i_cfg_data[asc_pkg::RANGE_W-1:0];
                asc_pkg::CFG_HIGH_THR:
                    r_cfg.high_threshold <= i_cfg_data[asc_pkg::THR_W-1:0];
                asc_pkg::CFG_LOW_THR:
                    r_cfg.low_threshold <= i_cfg_data[asc_pkg::THR_W-1:0];
                asc_pkg::CFG_RELOAD:
                    r_cfg.window_reload <= i_cfg_data;
                asc_pkg::CFG_MULT:
                    r_cfg.rate_multiplier <= i_cfg_data[asc_pkg::MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_en3      = !r_v3 || i_out_ready;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_in_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    asc_axis_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (w_en1),
        .i_raw    (i_x_raw),
        .i_range  (r_cfg.range_select),
        .o_abs_mg (w_abs_x)
    );

    asc_axis_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (w_en1),
        .i_raw    (i_y_raw),
        .i_range  (r_cfg.range_select),
        .o_abs_mg (w_abs_y)
    );

    asc_axis_lane u_lane_z (
        .i_clk    (i_clk),
        .i_en     (w_en1),
        .i_raw    (i_z_raw),
        .i_range  (r_cfg.range_select),
        .o_abs_mg (w_abs_z)
    );

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_mag <= {2'd0, w_abs_x} + {2'd0, w_abs_y} + {2'd0, w_abs_z};
        end
    end

    asc_step_tracker u_tracker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (w_en3 && r_v2),
        .i_mag              (r_mag),
        .i_cfg              (r_cfg),
        .o_magnitude_mg     (o_magnitude_mg),
        .o_step_seen        (o_step_seen),
        .o_step_total       (o_step_total),
        .o_rate_valid       (o_rate_valid),
        .o_steps_per_minute (o_steps_per_minute)
    );

    assign o_out_valid = r_v3;

endmodule
